@@ design/hopg_pkg.sv @@
// shared types, constants and helpers for the henon orbit pixel generator
// no dependencies; imported by every design module
package hopg_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int SCREEN_WIDTH  = 640;
  localparam int WINDOW_HEIGHT = 189;
  localparam int CENTER_X      = 370;
  localparam int CENTER_Y      = 105;
  localparam int SCALE_X       = 160;
  localparam int SCALE_Y       = 80;

  localparam int COL_W = 10;
  localparam int ROW_W = 8;

  // configuration register indexes
  localparam logic [2:0] REG_COS  = 3'd0;
  localparam logic [2:0] REG_SIN  = 3'd1;
  localparam logic [2:0] REG_SMIN = 3'd2;
  localparam logic [2:0] REG_SMAX = 3'd3;
  localparam logic [2:0] REG_STEP = 3'd4;
  localparam logic [2:0] REG_ITER = 3'd5;

  // multiplier issue slots within one map step
  localparam logic [2:0] SLOT_XX   = 3'd0;
  localparam logic [2:0] SLOT_XCOS = 3'd1;
  localparam logic [2:0] SLOT_XSIN = 3'd2;
  localparam logic [2:0] SLOT_PSIN = 3'd3;
  localparam logic [2:0] SLOT_PCOS = 3'd4;
  localparam logic [2:0] SLOT_NX   = 3'd5;
  localparam logic [2:0] SLOT_NY   = 3'd6;

  typedef logic signed [31:0] q_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_PIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             vis;
  } pix_t;

  // clamp a 33 bit signed sum to 32 bits
  function automatic q_t sat_sum(input logic signed [32:0] v);
    q_t r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else if (v[32]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

@@ design/henon_orbit_pixel_generator.sv @@
// top level: config registers, orbit state, sequencer and output register
// uses hopg_pkg, hopg_mulq and hopg_pixel
//
//  channel | dir | transfer when          | payload
//  in_     | in  | in_tvalid & in_tready  | tdata[0] restart
//  out_    | out | out_tvalid & out_tready| tdata x/y/visible, tlast orbit_last, tuser sweep_done
//  cfg_    | in  | cfg_valid & cfg_ready  | cfg_index register, cfg_data value
//
// each input transfer is taken in the idle state and passes through the seed check,
// the run state on the shared two-stage multiplier (five products), the pixel state
// and the output state before the block is ready again; a sweep-done item skips run and pixel.
// the output register is loaded only when empty or being drained, so a stalled
// output holds the block in its last state. reset is synchronous and active low;
// cfg_ready stays high.
module henon_orbit_pixel_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] pixel_x, [17:10] pixel_y, [18] visible, [23:19] zero
  output logic        out_tlast,  // orbit_last
  output logic        out_tuser,  // sweep_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hopg_pkg::*;

  localparam q_t RST_SMIN = -(32'sd1 <<< FRAC_BITS);
  localparam q_t RST_SMAX = 32'sd1 <<< FRAC_BITS;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r;

  logic signed [25:0] cos_r, sin_r;
  q_t                 seed_min_r, seed_max_r;
  logic [30:0]        seed_step_r;
  logic [15:0]        iter_r;

  q_t          orbit_x_r, orbit_y_r, seed_r;
  logic [15:0] step_r;
  logic        fin_r;

  q_t p_r, ax_r, ay_r;
  q_t cos_ext, sin_ext;
  q_t mul_a, mul_b, mul_res;

  pix_t pix;
  pix_t res_pix_r;
  logic res_last_r, res_done_r;

  logic out_valid_r;
  pix_t out_pix_r;
  logic out_last_r, out_done_r;

  logic                done_now;
  logic                last_pt;
  logic signed [32:0]  next_seed;
  logic                seed_ovf;
  logic                out_free;

  assign cos_ext = {{6{cos_r[25]}}, cos_r};
  assign sin_ext = {{6{sin_r[25]}}, sin_r};

  assign done_now  = fin_r || (step_r == '0 && seed_r > seed_max_r);
  assign last_pt   = (step_r == iter_r);
  assign next_seed = {seed_r[31], seed_r} + {2'b00, seed_step_r};
  assign seed_ovf  = !next_seed[32] && next_seed[31];
  assign out_free  = !out_valid_r || out_tready;

  hopg_mulq u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_res (mul_res)
  );

  hopg_pixel u_pix (
    .pt_x (orbit_x_r),
    .pt_y (orbit_y_r),
    .pix  (pix)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = done_now ? ST_OUT : ST_RUN;
      ST_RUN:   if (cnt_r == SLOT_NY) state_nxt = ST_PIX;
      ST_PIX:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    if (state_r == ST_RUN) begin
      case (cnt_r)
        SLOT_XX:   begin mul_a = orbit_x_r; mul_b = orbit_x_r; end
        SLOT_XCOS: begin mul_a = orbit_x_r; mul_b = cos_ext;   end
        SLOT_XSIN: begin mul_a = orbit_x_r; mul_b = sin_ext;   end
        SLOT_PSIN: begin mul_a = p_r;       mul_b = sin_ext;   end
        SLOT_PCOS: begin mul_a = p_r;       mul_b = cos_ext;   end
        default:   begin mul_a = '0;        mul_b = '0;        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cos_r       <= 26'sd1 <<< FRAC_BITS;
      sin_r       <= '0;
      seed_min_r  <= RST_SMIN;
      seed_max_r  <= RST_SMAX;
      seed_step_r <= 31'd167772;
      iter_r      <= 16'd255;
      orbit_x_r   <= RST_SMIN;
      orbit_y_r   <= RST_SMIN;
      seed_r      <= RST_SMIN;
      step_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_COS:  cos_r       <= cfg_data[25:0];
          REG_SIN:  sin_r       <= cfg_data[25:0];
          REG_SMIN: seed_min_r  <= cfg_data;
          REG_SMAX: seed_max_r  <= cfg_data;
          REG_STEP: seed_step_r <= cfg_data[30:0];
          REG_ITER: iter_r      <= cfg_data[15:0];
          default:  ;
        endcase
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tdata[0]) begin
            seed_r    <= seed_min_r;
            orbit_x_r <= seed_min_r;
            orbit_y_r <= seed_min_r;
            step_r    <= '0;
            fin_r     <= 1'b0;
          end
        end
        ST_CHECK: begin
          cnt_r <= '0;
          if (done_now) begin
            fin_r <= 1'b1;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 3'd1;
          case (cnt_r)
            SLOT_XSIN: p_r  <= sat_sum({orbit_y_r[31], orbit_y_r} - {mul_res[31], mul_res});
            SLOT_PSIN: ax_r <= mul_res;
            SLOT_PCOS: ay_r <= mul_res;
            SLOT_NX:   orbit_x_r <= sat_sum({ax_r[31], ax_r} - {mul_res[31], mul_res});
            SLOT_NY:   orbit_y_r <= sat_sum({ay_r[31], ay_r} + {mul_res[31], mul_res});
            default:   ;
          endcase
        end
        ST_PIX: begin
          if (last_pt) begin
            step_r <= '0;
            if (seed_ovf) begin
              fin_r <= 1'b1;
            end else begin
              seed_r    <= next_seed[31:0];
              orbit_x_r <= next_seed[31:0];
              orbit_y_r <= next_seed[31:0];
            end
          end else begin
            step_r <= step_r + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      res_pix_r  <= '0;
      res_last_r <= 1'b0;
      res_done_r <= 1'b1;
    end else if (state_r == ST_PIX) begin
      res_pix_r  <= pix;
      res_last_r <= last_pt;
      res_done_r <= 1'b0;
    end
    if (state_r == ST_OUT && out_free) begin
      out_pix_r  <= res_pix_r;
      out_last_r <= res_last_r;
      out_done_r <= res_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_pix_r.vis, out_pix_r.row, out_pix_r.col};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  // a sweep-done result carries no point
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0 && !out_tlast)
    else $error("sweep-done result carries point data");

  // an invisible point reports zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[18] |-> out_tdata[17:0] == '0)
    else $error("hidden point has nonzero coordinates");

  // a visible point lies inside the window
  a_vis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |->
      out_tdata[9:0] < COL_W'(SCREEN_WIDTH) && out_tdata[17:10] < ROW_W'(WINDOW_HEIGHT))
    else $error("visible point outside window");

  // the block takes one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready held across an input transfer");

endmodule

@@ design/hopg_mulq.sv @@
// shared fixed point multiplier: 32x32 product, floor shift and saturation
// two register stages; depends on hopg_pkg
module hopg_mulq (
  input  logic           clk,
  input  hopg_pkg::q_t   mul_a,
  input  hopg_pkg::q_t   mul_b,
  output hopg_pkg::q_t   mul_res
);
  import hopg_pkg::*;

  localparam int SH_W = 64 - FRAC_BITS;

  logic signed [63:0]     prod_r;
  logic signed [63:0]     prod_nxt;
  logic signed [SH_W-1:0] shifted;
  q_t                     res_r;
  q_t                     res_nxt;

  assign prod_nxt = mul_a * mul_b;
  // taking the top bits is a floor shift
  assign shifted  = prod_r[63:FRAC_BITS];

  always_comb begin
    if (&shifted[SH_W-1:31] || ~|shifted[SH_W-1:31]) begin
      res_nxt = shifted[31:0];
    end else if (shifted[SH_W-1]) begin
      res_nxt = 32'sh8000_0000;
    end else begin
      res_nxt = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign mul_res = res_r;

endmodule

@@ design/hopg_pixel.sv @@
// maps a new orbit point to a screen column and row with a window check
// combinational; depends on hopg_pkg
module hopg_pixel (
  input  hopg_pkg::q_t  pt_x,
  input  hopg_pkg::q_t  pt_y,
  output hopg_pkg::pix_t pix
);
  import hopg_pkg::*;

  localparam int VW = 42;
  localparam logic signed [VW-1:0] ONE_Q     = 42'sd1 <<< FRAC_BITS;
  localparam logic signed [VW-1:0] NEG_ONE_Q = -ONE_Q;
  localparam logic signed [VW-1:0] COL_OFS   = VW'(CENTER_X) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] ROW_OFS   = VW'(CENTER_Y) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] COL_LIM   = VW'(SCREEN_WIDTH) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] ROW_LIM   = VW'(WINDOW_HEIGHT) <<< FRAC_BITS;

  logic signed [VW-1:0] v_col;
  logic signed [VW-1:0] v_row;
  logic                 col_ok;
  logic                 row_ok;

  assign v_col = VW'(pt_x) * VW'(SCALE_X) + COL_OFS;
  assign v_row = ROW_OFS - VW'(pt_y) * VW'(SCALE_Y);

  // truncation toward zero gives 0 for anything above minus one
  assign col_ok = (v_col > NEG_ONE_Q) && (v_col < COL_LIM);
  assign row_ok = (v_row > NEG_ONE_Q) && (v_row < ROW_LIM);

  always_comb begin
    pix.vis = col_ok && row_ok;
    pix.col = '0;
    pix.row = '0;
    if (pix.vis && !v_col[VW-1]) begin
      pix.col = v_col[FRAC_BITS+COL_W-1:FRAC_BITS];
    end
    if (pix.vis && !v_row[VW-1]) begin
      pix.row = v_row[FRAC_BITS+ROW_W-1:FRAC_BITS];
    end
  end

endmodule

@@ tb/henon_orbit_pixel_generator_test.sv @@
// self-checking testbench for the henon orbit pixel generator
// predicts each pixel with its own fixed point model; needs hopg_pkg and the design only
module henon_orbit_pixel_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hopg_pkg::*;

  localparam int     LIMIT_CYCLES    = 1_000_000;
  localparam int     DRAIN_CYCLES    = 32;
  localparam int     PHASES          = 10;
  localparam int     ITEMS_PER_PHASE = 140;
  localparam int     PRESSURE_PHASE  = 4;
  localparam int     NOISE_PHASE     = 9;
  localparam int     LONG_HOLD       = 400;
  localparam longint Q_HI            = 64'sd2147483647;
  localparam longint Q_LO            = -64'sd2147483648;

  // indexes the block has no register behind
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             vis;
    logic             orbit_end;
    logic             done;
  } point_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] data;   // register value, or restart flag in bit 0
    logic        typed;
    point_t      want;
  } plan_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = 3'd0;
  logic [31:0] cfg_data   = 32'd0;

  int  cycle_count  = 0;
  int  mismatches   = 0;
  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  bit  pressure_go  = 1'b0;

  point_t    pending_points[$];
  plan_row_t plan[$];

  // predictor copy of registers and orbit state
  q_t          cos_q, sin_q, seed_lo, seed_hi;
  logic [30:0] seed_inc;
  logic [15:0] last_step;
  q_t          cur_x, cur_y, seed_now;
  logic [15:0] step_idx;
  logic        sweep_over;

  henon_orbit_pixel_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic q_t clamp_q(input longint v);
    if (v > Q_HI) return 32'sh7fff_ffff;
    if (v < Q_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // full product, floor shift, then clamp
  function automatic q_t qmul(input q_t a, input q_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clamp_q(prod >>> FRAC_BITS);
  endfunction

  // screen coordinates round toward zero
  function automatic longint trunc_frac(input longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v) >>> FRAC_BITS);
  endfunction

  function automatic void start_sweep();
    seed_now   = seed_lo;
    cur_x      = seed_lo;
    cur_y      = seed_lo;
    step_idx   = 16'd0;
    sweep_over = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] d);
    case (idx)
      REG_COS:  cos_q     = $signed(d[25:0]);
      REG_SIN:  sin_q     = $signed(d[25:0]);
      REG_SMIN: seed_lo   = d;
      REG_SMAX: seed_hi   = d;
      REG_STEP: seed_inc  = d[30:0];
      REG_ITER: last_step = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic point_t henon_step(input logic restart);
    point_t pt;
    q_t     p, nx, ny;
    longint cv, rv, nxt;
    logic   orbit_end;
    pt = '0;
    if (restart) start_sweep();
    if (!sweep_over && step_idx == 16'd0 && seed_now > seed_hi) sweep_over = 1'b1;
    if (sweep_over) begin
      pt.done = 1'b1;
      return pt;
    end
    p  = clamp_q(longint'(cur_y) - longint'(qmul(cur_x, cur_x)));
    nx = clamp_q(longint'(qmul(cur_x, cos_q)) - longint'(qmul(p, sin_q)));
    ny = clamp_q(longint'(qmul(cur_x, sin_q)) + longint'(qmul(p, cos_q)));
    cur_x = nx;
    cur_y = ny;
    cv = trunc_frac(longint'(SCALE_X) * longint'(nx) + (longint'(CENTER_X) <<< FRAC_BITS));
    rv = trunc_frac((longint'(CENTER_Y) <<< FRAC_BITS) - longint'(SCALE_Y) * longint'(ny));
    orbit_end = (step_idx == last_step);
    if (orbit_end) begin
      nxt = longint'(seed_now) + longint'(seed_inc);
      step_idx = 16'd0;
      if (nxt > Q_HI) begin
        sweep_over = 1'b1;
      end else begin
        seed_now = nxt[31:0];
        cur_x    = seed_now;
        cur_y    = seed_now;
      end
    end else begin
      step_idx = step_idx + 16'd1;
    end
    if (cv >= 0 && cv < SCREEN_WIDTH && rv >= 0 && rv < WINDOW_HEIGHT) begin
      pt.col = cv[COL_W-1:0];
      pt.row = rv[ROW_W-1:0];
      pt.vis = 1'b1;
    end
    pt.orbit_end = orbit_end;
    return pt;
  endfunction

  function automatic point_t pt(input int col, input int row, input logic vis,
                                input logic oend, input logic done);
    point_t r;
    r.col       = col[COL_W-1:0];
    r.row       = row[ROW_W-1:0];
    r.vis       = vis;
    r.orbit_end = oend;
    r.done      = done;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic restart, input logic typed,
                                         input point_t want);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.data  = {31'd0, restart};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [31:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %0s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic push_item(input logic restart, input logic typed, input point_t want);
    point_t guess;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    guess = henon_step(restart);
    pending_points.push_back(typed ? want : guess);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering items and wait for every pending pixel and a ready block
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0 || !in_tready) @(posedge clk);
  endtask

  task automatic program_phase(input bit noise);
    real ang;
    int  lo;
    if (noise) begin
      write_reg(REG_COS, $urandom);
      write_reg(REG_SIN, $urandom);
      write_reg(REG_SMIN, $urandom);
      write_reg(REG_SMAX, $urandom);
      write_reg(REG_STEP, $urandom);
      write_reg(REG_ITER, $urandom);
    end else begin
      ang = $urandom_range(0, 6283) / 1000.0;
      lo  = int'($urandom_range(0, 25165824)) - 16777216;
      write_reg(REG_COS, $rtoi($cos(ang) * 16777216.0));
      write_reg(REG_SIN, $rtoi($sin(ang) * 16777216.0));
      write_reg(REG_SMIN, lo);
      write_reg(REG_SMAX, lo + int'($urandom_range(0, 16777216)));
      write_reg(REG_STEP, $urandom_range(50000, 3000000));
      write_reg(REG_ITER, $urandom_range(0, 40));
    end
  endtask

  always @(negedge clk) begin : rx_driver
    int hold_cnt;
    bit hold_started;
    if (pressure_go && !hold_started) begin
      hold_started = 1'b1;
      hold_cnt     = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt   = hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.col       = out_tdata[9:0];
      got.row       = out_tdata[17:10];
      got.vis       = out_tdata[18];
      got.orbit_end = out_tlast;
      got.done      = out_tuser;
      if (pending_points.size() == 0) begin
        log_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = pending_points.pop_front();
        if (got.col !== want.col) log_mismatch("pixel_x", got.col, want.col);
        if (got.row !== want.row) log_mismatch("pixel_y", got.row, want.row);
        if (got.vis !== want.vis) log_mismatch("visible", got.vis, want.vis);
        if (got.orbit_end !== want.orbit_end)
          log_mismatch("orbit_last", got.orbit_end, want.orbit_end);
        if (got.done !== want.done) log_mismatch("sweep_done", got.done, want.done);
      end
    end
  end

  initial begin
    plan_row_t row;
    logic      rs;

    cos_q     = 32'sd16777216;
    sin_q     = 32'sd0;
    seed_lo   = -32'sd16777216;
    seed_hi   = 32'sd16777216;
    seed_inc  = 31'd167772;
    last_step = 16'd255;
    start_sweep();

    // seed -1.0 with no rotation lands below the window
    plan.push_back(item_row(1'b0, 1'b1, pt(0, 0, 0, 0, 0)));
    plan.push_back(item_row(1'b1, 1'b1, pt(0, 0, 0, 0, 0)));
    plan.push_back(reg_row(REG_ITER, 32'd0));
    plan.push_back(item_row(1'b1, 1'b1, pt(0, 0, 0, 1, 0)));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    // largest seed: square saturates, next seed overflows and ends the sweep
    plan.push_back(reg_row(REG_SMIN, 32'h7fff_ffff));
    plan.push_back(reg_row(REG_SMAX, 32'h7fff_ffff));
    plan.push_back(item_row(1'b1, 1'b1, pt(0, 0, 0, 1, 0)));
    plan.push_back(item_row(1'b0, 1'b1, pt(0, 0, 0, 0, 1)));
    // smallest seed: one orbit, then the seed passes seed_max
    plan.push_back(reg_row(REG_SMIN, 32'h8000_0000));
    plan.push_back(reg_row(REG_SMAX, 32'h8000_0000));
    plan.push_back(item_row(1'b1, 1'b1, pt(0, 0, 0, 1, 0)));
    plan.push_back(item_row(1'b0, 1'b1, pt(0, 0, 0, 0, 1)));
    // empty range
    plan.push_back(reg_row(REG_SMIN, 32'h0100_0000));
    plan.push_back(reg_row(REG_SMAX, 32'h0000_0000));
    plan.push_back(item_row(1'b1, 1'b1, pt(0, 0, 0, 0, 1)));
    // origin is a fixed point at the screen center
    plan.push_back(reg_row(REG_SMAX, 32'h7fff_ffff));
    plan.push_back(reg_row(REG_SMIN, 32'h0000_0000));
    plan.push_back(item_row(1'b1, 1'b1, pt(CENTER_X, CENTER_Y, 1, 1, 0)));
    plan.push_back(reg_row(REG_ITER, 32'd3));
    plan.push_back(reg_row(REG_COS, 32'h0200_0000));
    plan.push_back(reg_row(REG_SIN, 32'h01ff_ffff));
    plan.push_back(item_row(1'b1, 1'b1, pt(CENTER_X, CENTER_Y, 1, 0, 0)));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    // upper bits above the 26 bit angle fields are ignored
    plan.push_back(reg_row(REG_COS, 32'hff00_0000));
    plan.push_back(reg_row(REG_SIN, 32'hffff_ffff));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    // zero step repeats one orbit
    plan.push_back(reg_row(REG_COS, 32'd4026532));
    plan.push_back(reg_row(REG_SIN, 32'd16286978));
    plan.push_back(reg_row(REG_SMIN, 32'hff80_0000));
    plan.push_back(reg_row(REG_SMAX, 32'h0080_0000));
    plan.push_back(reg_row(REG_STEP, 32'd0));
    plan.push_back(reg_row(REG_ITER, 32'd1));
    plan.push_back(item_row(1'b1, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));
    plan.push_back(reg_row(REG_STEP, 32'hffff_ffff));
    plan.push_back(reg_row(REG_ITER, 32'hffff_ffff));
    plan.push_back(reg_row(REG_SPARE_LO, 32'h5a5a_a5a5));
    plan.push_back(reg_row(REG_SPARE_HI, 32'ha5a5_5a5a));
    plan.push_back(item_row(1'b1, 1'b0, '0));
    plan.push_back(item_row(1'b0, 1'b0, '0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        push_item(row.data[0], row.typed, row.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      case (ph % 4)
        1: tx_idle_pct = 77;
        2: rx_stall_pct = 77;
        3: begin
          tx_idle_pct  = 34;
          rx_stall_pct = 34;
        end
        default: ;
      endcase
      if (ph == PRESSURE_PHASE) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      program_phase(ph == NOISE_PHASE);
      // receiver goes quiet while items keep coming
      if (ph == PRESSURE_PHASE) pressure_go = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        rs = sweep_over ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 59) == 0);
        if (k == 0) rs = 1'b1;
        push_item(rs, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
